// ----- rtl/core/tlpq_pkg.sv -----
// Shared constants and types of the three-level priority queue.
package tlpq_pkg;

  // Capacity of the whole queue, summed over all levels
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned NumLevels  = 3;

  localparam int unsigned IdW     = 16;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned PtrW    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW    = $clog2(QueueDepth + 1);

  // Each level owns one ring of 2**PtrW words; the level index forms the upper bits
  localparam int unsigned RamAddrW = PtrW + IdxW;
  localparam int unsigned RamDepth = NumLevels * (1 << PtrW);

  typedef enum logic {
    MODE_ADD  = 1'b0,
    MODE_TAKE = 1'b1
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STAT_ADDED = 2'd0,
    STAT_TAKEN = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_TAKE = 1'b1
  } state_e;

endpackage

// ----- rtl/core/tlpq_ram.sv -----
// Single-port synchronous RAM with registered read data.
module tlpq_ram #(
  parameter int unsigned DataW = 16,
  parameter int unsigned Depth = 48,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];

  // Write on enable with we, otherwise read into the output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

// ----- rtl/core/three_level_priority_queue_top.sv -----
// Top level of the three-level priority queue: level rings, pointers and result register.
//
// Input channel (in_valid_i / in_stall_o): mode_i 0 adds item_id_i at level urgency_i
// (1 most urgent, 0 treated as 1), mode_i 1 takes the most urgent waiting word,
// oldest first within a level. Each input word yields exactly one result word on
// the output channel (out_valid_o / out_stall_i): status_o, taken_id_o, taken_level_o.
// Storage is one single-port RAM split into three rings, one per level, with head,
// tail and count registers per level; the total fill is capped at QueueDepth.
// For an add, a full add and a take on an empty queue the result word is registered
// at the edge that accepts the input. A successful take first registers the RAM read
// data and enters the read-back state, which then loads the result word from it.
// No new input word is accepted while a take is in its read-back state.
// Reset empties the queue (all counts and pointers clear); RAM contents stay as
// they were and are never read before being written again.
// While a result waits under out_stall_i, in_stall_o stays high; the result
// payload holds until it is taken.
module three_level_priority_queue_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [tlpq_pkg::IdW-1:0]    item_id_i,
  input  logic [tlpq_pkg::LevelW-1:0] urgency_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tlpq_pkg::StatusW-1:0] status_o,
  output logic [tlpq_pkg::IdW-1:0]    taken_id_o,
  output logic [tlpq_pkg::LevelW-1:0] taken_level_o
);

  tlpq_pkg::state_e state_q, state_d;

  logic [tlpq_pkg::PtrW-1:0] head_q [tlpq_pkg::NumLevels];
  logic [tlpq_pkg::PtrW-1:0] tail_q [tlpq_pkg::NumLevels];
  logic [tlpq_pkg::CntW-1:0] cnt_q  [tlpq_pkg::NumLevels];
  logic [tlpq_pkg::CntW-1:0] occ_q;
  logic [tlpq_pkg::IdxW-1:0] take_idx_q;

  logic                          out_valid_q;
  tlpq_pkg::status_e             status_q;
  logic [tlpq_pkg::IdW-1:0]      out_id_q;
  logic [tlpq_pkg::LevelW-1:0]   out_level_q;

  logic                          out_free;
  logic                          accept;
  logic                          is_full;
  logic                          is_empty;
  logic                          add_ok;
  logic                          take_ok;
  logic                          load_imm;
  logic                          load_take;
  tlpq_pkg::status_e             imm_status;
  logic [tlpq_pkg::IdxW-1:0]     in_idx;
  logic [tlpq_pkg::IdxW-1:0]     take_idx;
  logic [tlpq_pkg::PtrW-1:0]     tail_sel;
  logic [tlpq_pkg::PtrW-1:0]     head_sel;
  logic [tlpq_pkg::RamAddrW-1:0] ram_addr;
  logic [tlpq_pkg::IdW-1:0]      ram_rdata;
  logic [tlpq_pkg::CntW+1:0]     occ_sum;

  // Advance a ring pointer, wrapping at the capacity
  function automatic logic [tlpq_pkg::PtrW-1:0] ptr_inc(input logic [tlpq_pkg::PtrW-1:0] p);
    logic [tlpq_pkg::PtrW-1:0] r;
    if (p == tlpq_pkg::PtrW'(tlpq_pkg::QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Map the urgency field onto a ring index; zero counts as the most urgent level
  always_comb begin
    case (urgency_i) inside
      2'd0, 2'd1: in_idx = 2'd0;
      2'd2:       in_idx = 2'd1;
      default:    in_idx = 2'd2;
    endcase
  end

  // Pick the most urgent non-empty level
  always_comb begin
    if (cnt_q[0] != '0) begin
      take_idx = 2'd0;
    end else if (cnt_q[1] != '0) begin
      take_idx = 2'd1;
    end else begin
      take_idx = 2'd2;
    end
  end

  assign tail_sel = tail_q[in_idx];
  assign head_sel = head_q[take_idx];
  assign is_full  = (occ_q == tlpq_pkg::CntW'(tlpq_pkg::QueueDepth));
  assign is_empty = (occ_q == '0);
  assign out_free = !out_valid_q || !out_stall_i;

  // Handshake and result-load control
  always_comb begin
    in_stall_o = !((state_q == tlpq_pkg::S_IDLE) && out_free);
    load_take  = (state_q == tlpq_pkg::S_TAKE) && out_free;
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign add_ok   = accept && (mode_i == tlpq_pkg::MODE_ADD) && !is_full;
  assign take_ok  = accept && (mode_i == tlpq_pkg::MODE_TAKE) && !is_empty;
  assign load_imm = accept && !take_ok;

  always_comb begin
    if (mode_i == tlpq_pkg::MODE_TAKE) begin
      imm_status = tlpq_pkg::STAT_EMPTY;
    end else if (is_full) begin
      imm_status = tlpq_pkg::STAT_FULL;
    end else begin
      imm_status = tlpq_pkg::STAT_ADDED;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tlpq_pkg::S_IDLE: begin
        if (take_ok) begin
          state_d = tlpq_pkg::S_TAKE;
        end
      end
      tlpq_pkg::S_TAKE: begin
        if (out_free) begin
          state_d = tlpq_pkg::S_IDLE;
        end
      end
      default: state_d = tlpq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlpq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Write at the tail of the add level, read at the head of the take level
  assign ram_addr = add_ok ? {in_idx, tail_sel} : {take_idx, head_sel};

  tlpq_ram #(
    .DataW(tlpq_pkg::IdW),
    .Depth(tlpq_pkg::RamDepth),
    .AddrW(tlpq_pkg::RamAddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (add_ok || take_ok),
    .we_i   (add_ok),
    .addr_i (ram_addr),
    .wdata_i(item_id_i),
    .rdata_o(ram_rdata)
  );

  // Update pointers and counts at acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tlpq_pkg::NumLevels; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      occ_q      <= '0;
      take_idx_q <= '0;
    end else begin
      if (add_ok) begin
        tail_q[in_idx] <= ptr_inc(tail_sel);
        cnt_q[in_idx]  <= cnt_q[in_idx] + 1'b1;
        occ_q          <= occ_q + 1'b1;
      end else if (take_ok) begin
        head_q[take_idx] <= ptr_inc(head_sel);
        cnt_q[take_idx]  <= cnt_q[take_idx] - 1'b1;
        occ_q            <= occ_q - 1'b1;
        take_idx_q       <= take_idx;
      end
    end
  end

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_imm || load_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload: immediate status or the word read back
  always_ff @(posedge clk_i) begin
    if (load_take) begin
      status_q    <= tlpq_pkg::STAT_TAKEN;
      out_id_q    <= ram_rdata;
      out_level_q <= take_idx_q + 1'b1;
    end else if (load_imm) begin
      status_q    <= imm_status;
      out_id_q    <= '0;
      out_level_q <= '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign taken_id_o    = out_id_q;
  assign taken_level_o = out_level_q;

  assign occ_sum = (tlpq_pkg::CntW+2)'(cnt_q[0]) + (tlpq_pkg::CntW+2)'(cnt_q[1])
                 + (tlpq_pkg::CntW+2)'(cnt_q[2]);

`ifndef NO_ASSERTIONS
  // Total fill matches the per-level counts
  a_occ_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_sum == (tlpq_pkg::CntW+2)'(occ_q))
    else $error("occupancy differs from the sum of level counts");

  // Fill never exceeds capacity
  a_occ_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= tlpq_pkg::CntW'(tlpq_pkg::QueueDepth))
    else $error("occupancy above capacity");

  // A successful take always leads to the read-back state
  a_take_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_ok |=> state_q == tlpq_pkg::S_TAKE)
    else $error("take did not enter read-back state");

  // Leaving the read-back state presents a taken result
  a_take_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_take |=> out_valid_q && status_q == tlpq_pkg::STAT_TAKEN && out_level_q != '0)
    else $error("read-back did not produce a taken result");
`endif

endmodule
